### src/mmc3bm_pkg.sv
// types and constants shared by the multicart mmc3 bank mapper
`timescale 1ns / 1ps
package mmc3bm_pkg;

  localparam int unsigned PrgBankW = 5;
  localparam int unsigned ChrBankW = 8;
  localparam int unsigned RawW     = 8;
  localparam int unsigned PrgSlots = 4;
  localparam int unsigned ChrSlots = 8;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 88;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [PrgBankW-1:0] PrgLastReset = 5'd31;
  localparam logic [ChrBankW-1:0] ChrLastReset = 8'd255;

  localparam logic [15:0] RegSelMask  = 16'hE001;
  localparam logic [15:0] RegModeAddr = 16'h8000;
  localparam logic [15:0] RegBankAddr = 16'h8001;
  localparam logic [2:0]  OuterAddrHi = 3'b011;

  localparam logic [RawW-1:0] PrgRawMask = 8'h0F;
  localparam logic [RawW-1:0] ChrRawMask = 8'h7F;

  // bank select index codes
  localparam logic [2:0] BankChr2kLo = 3'd0;
  localparam logic [2:0] BankChr2kHi = 3'd1;
  localparam logic [2:0] BankChr1kA  = 3'd2;
  localparam logic [2:0] BankChr1kB  = 3'd3;
  localparam logic [2:0] BankChr1kC  = 3'd4;
  localparam logic [2:0] BankChr1kD  = 3'd5;
  localparam logic [2:0] BankPrgSwap = 3'd6;
  localparam logic [2:0] BankPrgMid  = 3'd7;

  // config register indexes
  localparam logic RegPrgLast = 1'b0;
  localparam logic RegChrLast = 1'b1;

  typedef struct packed {
    logic                           outer_select;
    logic [2:0]                     bank_index;
    logic                           prg_mode;
    logic                           chr_mode;
    logic [PrgSlots-1:0][RawW-1:0]  prg_raw;
    logic [ChrSlots-1:0][RawW-1:0]  chr_raw;
  } bank_state_t;

  typedef struct packed {
    logic [ChrSlots-1:0][ChrBankW-1:0] chr_bank;
    logic [PrgSlots-1:0][PrgBankW-1:0] prg_bank;
  } bank_out_t;

endpackage

### src/mmc3bm_bank_limit.sv
// joins the outer select into the raw banks and masks banks above the limits
`timescale 1ns / 1ps
module mmc3bm_bank_limit (
  input  mmc3bm_pkg::bank_state_t               state_i,
  input  logic [mmc3bm_pkg::PrgBankW-1:0]       prg_last_i,
  input  logic [mmc3bm_pkg::ChrBankW-1:0]       chr_last_i,
  output mmc3bm_pkg::bank_out_t                 banks_o
);
  import mmc3bm_pkg::*;

  logic [PrgSlots-1:0][PrgBankW-1:0] prg_full;
  logic [ChrSlots-1:0][ChrBankW-1:0] chr_full;

  always_comb begin
    for (int k = 0; k < PrgSlots; k++) begin
      prg_full[k] = {state_i.outer_select, state_i.prg_raw[k][3:0]};
      banks_o.prg_bank[k] = (prg_full[k] > prg_last_i) ? (prg_full[k] & prg_last_i)
                                                       : prg_full[k];
    end
    for (int k = 0; k < ChrSlots; k++) begin
      chr_full[k] = {state_i.outer_select, state_i.chr_raw[k][6:0]};
      banks_o.chr_bank[k] = (chr_full[k] > chr_last_i) ? (chr_full[k] & chr_last_i)
                                                       : chr_full[k];
    end
  end

endmodule

### src/multicart_mmc3_bank_mapper.sv
// multicart mmc3 bank mapper: cpu write decode, bank state and effective bank output
// the output register captures each accepted request's result together with its state update
// throughput: one request per cycle unless the output is stalled, set by the single state update and output register
// reset: outer select, index and modes cleared, prg raw banks 0/1/30/31, chr raw 0..7
// reset: prg limit 31, chr limit 255, no result pending
`timescale 1ns / 1ps
module multicart_mmc3_bank_mapper (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_tvalid_i,
  output logic                                 s_tready_o,
  // cpu_address[15:0], write_data[23:16]
  input  logic [mmc3bm_pkg::InDataW-1:0]       s_tdata_i,
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  // prg_bank_slot0..3 [19:0] (5 bits each), chr_bank_slot0..7 [83:20] (8 bits each), zeros
  output logic [mmc3bm_pkg::OutDataW-1:0]      m_tdata_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mmc3bm_pkg::ApbAddrW-1:0]      paddr,
  input  logic [mmc3bm_pkg::ApbDataW-1:0]      pwdata,
  output logic [mmc3bm_pkg::ApbDataW-1:0]      prdata,
  output logic                                 pready
);
  import mmc3bm_pkg::*;

  bank_state_t        st_q, st_d;
  bank_out_t          banks;
  logic [PrgBankW-1:0] prg_last_q;
  logic [ChrBankW-1:0] chr_last_q;
  logic               valid_q;
  logic [OutDataW-1:0] data_q;
  logic               in_fire;
  logic               cfg_wr;
  logic [15:0]        addr;
  logic [7:0]         wdata;
  logic [RawW-1:0]    even;
  logic [RawW-1:0]    second_last;
  logic [RawW-1:0]    prg_tmp;
  logic               new_prg;
  logic               new_chr;

  assign s_tready_o = !valid_q || m_tready_i;
  assign in_fire    = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = data_q;
  assign addr       = s_tdata_i[15:0];
  assign wdata      = s_tdata_i[23:16];
  assign even       = {wdata[7:1], 1'b0};
  assign second_last = {3'b000, prg_last_q} - 8'd1;
  assign new_prg    = wdata[6];
  assign new_chr    = wdata[7];

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      RegPrgLast: prdata = {{(ApbDataW-PrgBankW){1'b0}}, prg_last_q};
      default:    prdata = {{(ApbDataW-ChrBankW){1'b0}}, chr_last_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_last_q <= PrgLastReset;
      chr_last_q <= ChrLastReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegPrgLast: prg_last_q <= pwdata[PrgBankW-1:0];
        default:    chr_last_q <= pwdata[ChrBankW-1:0];
      endcase
    end
  end

  // bank state update
  always_comb begin
    st_d    = st_q;
    prg_tmp = st_q.prg_raw[0];
    if (in_fire) begin
      if (addr[15]) begin
        if ((addr & RegSelMask) == RegModeAddr) begin
          st_d.bank_index = wdata[2:0];
          st_d.chr_mode   = new_chr;
          st_d.prg_mode   = new_prg;
          if (new_chr != st_q.chr_mode) begin
            for (int k = 0; k < 4; k++) begin
              st_d.chr_raw[k]     = st_q.chr_raw[k + 4];
              st_d.chr_raw[k + 4] = st_q.chr_raw[k];
            end
          end
          if (new_prg != st_q.prg_mode) begin
            if (new_prg) begin
              st_d.prg_raw[0] = second_last;
              st_d.prg_raw[2] = prg_tmp;
            end else begin
              st_d.prg_raw[0] = st_q.prg_raw[2];
              st_d.prg_raw[2] = second_last;
            end
          end
        end else if ((addr & RegSelMask) == RegBankAddr) begin
          unique case (st_q.bank_index)
            BankChr2kLo: begin
              st_d.chr_raw[{st_q.chr_mode, 2'd0}] = even;
              st_d.chr_raw[{st_q.chr_mode, 2'd1}] = even | 8'd1;
            end
            BankChr2kHi: begin
              st_d.chr_raw[{st_q.chr_mode, 2'd2}] = even;
              st_d.chr_raw[{st_q.chr_mode, 2'd3}] = even | 8'd1;
            end
            BankChr1kA, BankChr1kB, BankChr1kC, BankChr1kD: begin
              st_d.chr_raw[{!st_q.chr_mode, 2'(st_q.bank_index - 3'd2)}] = wdata;
            end
            BankPrgSwap: begin
              st_d.prg_raw[{st_q.prg_mode, 1'b0}] = wdata;
            end
            default: begin
              st_d.prg_raw[1] = wdata;
            end
          endcase
        end
      end else if (addr[15:13] == OuterAddrHi) begin
        st_d.outer_select = wdata[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.outer_select <= 1'b0;
      st_q.bank_index   <= 3'd0;
      st_q.prg_mode     <= 1'b0;
      st_q.chr_mode     <= 1'b0;
      st_q.prg_raw[0]   <= 8'd0;
      st_q.prg_raw[1]   <= 8'd1;
      st_q.prg_raw[2]   <= {3'b000, PrgLastReset} - 8'd1;
      st_q.prg_raw[3]   <= {3'b000, PrgLastReset};
      for (int k = 0; k < ChrSlots; k++) begin
        st_q.chr_raw[k] <= 8'(k);
      end
    end else begin
      st_q <= st_d;
    end
  end

  mmc3bm_bank_limit u_limit (
    .state_i    (st_d),
    .prg_last_i (prg_last_q),
    .chr_last_i (chr_last_q),
    .banks_o    (banks)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_tready_o) begin
      valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q <= {{(OutDataW - $bits(bank_out_t)){1'b0}}, banks};
    end
  end

endmodule
